[sv/qbp_pkg.sv]
// shared types and constants for the quadratic bezier point unit
package qbp_pkg;

    localparam int unsigned COORD_W     = 32;
    localparam int unsigned CNT_W       = 16;
    localparam int unsigned AXES        = 3;
    localparam int unsigned T_FRAC_BITS = 16;
    // restoring divide steps per pipeline stage
    localparam int unsigned DIV_STEPS   = 4;

    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // index 0 = x, 1 = y, 2 = z
    typedef logic [AXES-1:0][COORD_W-1:0] qbp_vec_t;

    typedef struct packed {
        qbp_vec_t s;
        qbp_vec_t c;
        qbp_vec_t e;
    } qbp_pts_t;

endpackage

[sv/qbp_t_div.sv]
// pipelined restoring divider forming t = index / count as an unsigned fraction
module qbp_t_div #(
    parameter int unsigned T_FRAC_BITS = qbp_pkg::T_FRAC_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  qbp_pkg::qbp_pts_t            in_pts,
    input  logic                         in_err,
    input  logic                         in_qint,
    input  logic [qbp_pkg::CNT_W-1:0]    in_rem,
    input  logic [qbp_pkg::CNT_W-1:0]    in_cnt,
    output logic                         out_valid,
    input  logic                         out_ready,
    output qbp_pkg::qbp_pts_t            out_pts,
    output logic                         out_err,
    output logic [T_FRAC_BITS:0]         out_t
);

    localparam int unsigned CW = qbp_pkg::CNT_W;
    localparam int unsigned TW = T_FRAC_BITS + 1;
    localparam int unsigned NS = (T_FRAC_BITS + qbp_pkg::DIV_STEPS - 1) / qbp_pkg::DIV_STEPS;

    logic [NS:0]        en;
    logic               valid_reg [NS];
    logic [CW-1:0]      rem_reg   [NS];
    logic [CW-1:0]      cnt_reg   [NS];
    logic [TW-1:0]      q_reg     [NS];
    logic               err_reg   [NS];
    qbp_pkg::qbp_pts_t  pts_reg   [NS];

    logic               src_v     [NS];
    logic [CW-1:0]      src_rem   [NS];
    logic [CW-1:0]      src_cnt   [NS];
    logic [TW-1:0]      src_q     [NS];
    logic               src_err   [NS];
    qbp_pkg::qbp_pts_t  src_pts   [NS];

    logic [CW-1:0]      rem_next  [NS];
    logic [TW-1:0]      q_next    [NS];

    // a stage loads when it is empty or its content moves on
    always_comb begin
        en[NS] = out_ready;
        for (int s = NS - 1; s >= 0; s--) begin
            en[s] = !valid_reg[s] || en[s+1];
        end
    end

    always_comb begin
        src_v[0]   = in_valid;
        src_rem[0] = in_rem;
        src_cnt[0] = in_cnt;
        src_q[0]   = {{T_FRAC_BITS{1'b0}}, in_qint};
        src_err[0] = in_err;
        src_pts[0] = in_pts;
        for (int s = 1; s < NS; s++) begin
            src_v[s]   = valid_reg[s-1];
            src_rem[s] = rem_reg[s-1];
            src_cnt[s] = cnt_reg[s-1];
            src_q[s]   = q_reg[s-1];
            src_err[s] = err_reg[s-1];
            src_pts[s] = pts_reg[s-1];
        end
    end

    // each stage retires up to DIV_STEPS quotient bits
    always_comb begin
        logic [CW:0]   r2;
        logic [CW-1:0] r;
        logic [TW-1:0] q;
        logic          b;
        for (int s = 0; s < NS; s++) begin
            r = src_rem[s];
            q = src_q[s];
            for (int j = 0; j < qbp_pkg::DIV_STEPS; j++) begin
                if (s * qbp_pkg::DIV_STEPS + j < T_FRAC_BITS) begin
                    r2 = {r, 1'b0};
                    b  = (r2 >= {1'b0, src_cnt[s]});
                    if (b) begin
                        r2 = r2 - {1'b0, src_cnt[s]};
                    end
                    r = r2[CW-1:0];
                    q = {q[TW-2:0], b};
                end
            end
            rem_next[s] = r;
            q_next[s]   = q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NS; s++) begin
                valid_reg[s] <= 1'b0;
            end
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (en[s]) begin
                    valid_reg[s] <= src_v[s];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < NS; s++) begin
            if (en[s]) begin
                rem_reg[s] <= rem_next[s];
                cnt_reg[s] <= src_cnt[s];
                q_reg[s]   <= q_next[s];
                err_reg[s] <= src_err[s];
                pts_reg[s] <= src_pts[s];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NS-1];
    assign out_pts   = pts_reg[NS-1];
    assign out_err   = err_reg[NS-1];
    assign out_t     = q_reg[NS-1];

endmodule

[sv/quadratic_bezier_point_unit.sv]
// top level: quadratic bezier curve point, one request per cycle while m_ready stays high
//
// usage
//   s_* carries start, control and end points (signed Q16.16) plus a point
//   index and segment count; m_* returns the curve point per axis, saturated
//   to Q16.16, and a flag set when the segment count was zero.
//   both channels use valid/ready; a request moves on when both are high.
// pipeline and throughput
//   a request passes stage a, the NS divider stages, then stages w, p and m,
//   with NS = ceil(T_FRAC_BITS / 4) divider stages.
//   one request per cycle is taken while m_ready stays high; the divider stages,
//   four quotient bits each, set the depth.
// reset and stall
//   reset empties every stage; no result is shown until new requests arrive.
//   when m_ready is low the result holds and the stages behind it keep
//   filling bubbles; s_ready drops only once every stage holds a request.
module quadratic_bezier_point_unit #(
    parameter int unsigned T_FRAC_BITS = qbp_pkg::T_FRAC_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [qbp_pkg::COORD_W-1:0] s_start_x,
    input  logic signed [qbp_pkg::COORD_W-1:0] s_start_y,
    input  logic signed [qbp_pkg::COORD_W-1:0] s_start_z,
    input  logic signed [qbp_pkg::COORD_W-1:0] s_control_x,
    input  logic signed [qbp_pkg::COORD_W-1:0] s_control_y,
    input  logic signed [qbp_pkg::COORD_W-1:0] s_control_z,
    input  logic signed [qbp_pkg::COORD_W-1:0] s_end_x,
    input  logic signed [qbp_pkg::COORD_W-1:0] s_end_y,
    input  logic signed [qbp_pkg::COORD_W-1:0] s_end_z,
    input  logic        [qbp_pkg::CNT_W-1:0]   s_point_index,
    input  logic        [qbp_pkg::CNT_W-1:0]   s_segment_count,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [qbp_pkg::COORD_W-1:0] m_curve_x,
    output logic signed [qbp_pkg::COORD_W-1:0] m_curve_y,
    output logic signed [qbp_pkg::COORD_W-1:0] m_curve_z,
    output logic                             m_zero_count_error
);

    localparam int unsigned CW  = qbp_pkg::CNT_W;
    localparam int unsigned XW  = qbp_pkg::COORD_W;
    localparam int unsigned NA  = qbp_pkg::AXES;
    localparam int unsigned TW  = T_FRAC_BITS + 1;
    localparam int unsigned PW  = XW + TW + 1;
    localparam int unsigned SW  = XW + 2;
    localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    // stage a: clamp and divider setup
    logic              a_valid_reg;
    qbp_pkg::qbp_pts_t a_pts_reg;
    logic              a_err_reg;
    logic              a_qint_reg;
    logic [CW-1:0]     a_rem_reg;
    logic [CW-1:0]     a_cnt_reg;
    logic              a_en;
    logic              a_div_ready;

    qbp_pkg::qbp_pts_t a_pts_next;
    logic [CW-1:0]     a_idx_clamp;
    logic              a_qint_next;

    // divider output
    logic              d_valid;
    logic              d_ready;
    qbp_pkg::qbp_pts_t d_pts;
    logic              d_err;
    logic [TW-1:0]     d_t;

    // stage w: blend weights
    logic              w_valid_reg;
    qbp_pkg::qbp_pts_t w_pts_reg;
    logic              w_err_reg;
    logic [TW-1:0]     w0_reg, w1_reg, w2_reg;
    logic              w_en;
    logic [TW-1:0]     t_eff, u_val;
    logic [2*TW-1:0]   uu, ut, tt;

    // stage p: weighted terms
    logic              p_valid_reg;
    logic              p_err_reg;
    logic signed [XW-1:0] term_reg [NA][3];
    logic signed [PW-1:0] prod     [NA][3];
    logic              p_en;

    // stage m: sum and saturate
    logic              m_valid_reg;
    logic              m_err_reg;
    logic [XW-1:0]     curve_reg  [NA];
    logic [XW-1:0]     curve_next [NA];
    logic signed [SW-1:0] sum     [NA];
    logic              m_en;

    assign m_en    = !m_valid_reg || m_ready;
    assign p_en    = !p_valid_reg || m_en;
    assign w_en    = !w_valid_reg || p_en;
    assign d_ready = w_en;

    // ---------------- stage a
    assign a_en    = !a_valid_reg || a_div_ready;
    assign s_ready = a_en;

    always_comb begin
        a_pts_next.s = {s_start_z, s_start_y, s_start_x};
        a_pts_next.c = {s_control_z, s_control_y, s_control_x};
        a_pts_next.e = {s_end_z, s_end_y, s_end_x};
        a_idx_clamp  = (s_point_index > s_segment_count) ? s_segment_count : s_point_index;
        // index equal to count gives t = 1.0 exactly
        a_qint_next  = (s_segment_count != '0) && (a_idx_clamp == s_segment_count);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_en) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_en) begin
            a_pts_reg  <= a_pts_next;
            a_err_reg  <= (s_segment_count == '0);
            a_qint_reg <= a_qint_next;
            a_rem_reg  <= a_qint_next ? '0 : a_idx_clamp;
            a_cnt_reg  <= s_segment_count;
        end
    end

    qbp_t_div #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_t_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (a_valid_reg),
        .in_ready  (a_div_ready),
        .in_pts    (a_pts_reg),
        .in_err    (a_err_reg),
        .in_qint   (a_qint_reg),
        .in_rem    (a_rem_reg),
        .in_cnt    (a_cnt_reg),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_pts   (d_pts),
        .out_err   (d_err),
        .out_t     (d_t)
    );

    // ---------------- stage w
    always_comb begin
        // zero count forces t to 0, masking the divider's meaningless quotient
        t_eff = d_err ? '0 : d_t;
        u_val = T_ONE - t_eff;
        uu    = u_val * u_val;
        ut    = u_val * t_eff;
        tt    = t_eff * t_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg <= 1'b0;
        end else if (w_en) begin
            w_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (w_en) begin
            w_pts_reg <= d_pts;
            w_err_reg <= d_err;
            w0_reg    <= uu[2*T_FRAC_BITS:T_FRAC_BITS];
            // 2*u*t >> T is u*t >> (T-1)
            w1_reg    <= ut[2*T_FRAC_BITS-1:T_FRAC_BITS-1];
            w2_reg    <= tt[2*T_FRAC_BITS:T_FRAC_BITS];
        end
    end

    // ---------------- stage p
    always_comb begin
        for (int a = 0; a < NA; a++) begin
            prod[a][0] = $signed(w_pts_reg.s[a]) * $signed({1'b0, w0_reg});
            prod[a][1] = $signed(w_pts_reg.c[a]) * $signed({1'b0, w1_reg});
            prod[a][2] = $signed(w_pts_reg.e[a]) * $signed({1'b0, w2_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (p_en) begin
            p_valid_reg <= w_valid_reg;
        end
    end

    // dropping the low bits of a two's complement product floors it
    always_ff @(posedge aclk) begin
        if (p_en) begin
            p_err_reg <= w_err_reg;
            for (int a = 0; a < NA; a++) begin
                for (int k = 0; k < 3; k++) begin
                    term_reg[a][k] <= prod[a][k][T_FRAC_BITS+XW-1:T_FRAC_BITS];
                end
            end
        end
    end

    // ---------------- stage m
    always_comb begin
        for (int a = 0; a < NA; a++) begin
            sum[a] = $signed({{2{term_reg[a][0][XW-1]}}, term_reg[a][0]})
                   + $signed({{2{term_reg[a][1][XW-1]}}, term_reg[a][1]})
                   + $signed({{2{term_reg[a][2][XW-1]}}, term_reg[a][2]});
            if ((sum[a][SW-1] == sum[a][SW-2]) && (sum[a][SW-2] == sum[a][XW-1])) begin
                curve_next[a] = sum[a][XW-1:0];
            end else if (sum[a][SW-1]) begin
                curve_next[a] = qbp_pkg::COORD_MIN;
            end else begin
                curve_next[a] = qbp_pkg::COORD_MAX;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_en) begin
            m_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_en) begin
            m_err_reg <= p_err_reg;
            for (int a = 0; a < NA; a++) begin
                curve_reg[a] <= curve_next[a];
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_curve_x          = curve_reg[0];
    assign m_curve_y          = curve_reg[1];
    assign m_curve_z          = curve_reg[2];
    assign m_zero_count_error = m_err_reg;

endmodule

[sv/qbp_checker.sv]
// port-level checker for the quadratic bezier point unit, with its bind
module qbp_checker #(
    parameter int unsigned T_FRAC_BITS = qbp_pkg::T_FRAC_BITS
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic [qbp_pkg::CNT_W-1:0]        s_segment_count,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [qbp_pkg::COORD_W-1:0]      m_curve_x,
    input logic [qbp_pkg::COORD_W-1:0]      m_curve_y,
    input logic [qbp_pkg::COORD_W-1:0]      m_curve_z,
    input logic                             m_zero_count_error
);

    localparam int unsigned NS    = (T_FRAC_BITS + qbp_pkg::DIV_STEPS - 1) / qbp_pkg::DIV_STEPS;
    localparam int unsigned DEPTH = NS + 3;
    localparam int unsigned RW    = $clog2(DEPTH + 1);
    localparam logic [RW-1:0] RUN_FULL = RW'(DEPTH);

    // consecutive edges with m_ready high, saturating
    logic [RW-1:0] run_reg;
    logic [RW-1:0] run_next;

    always_comb begin
        if (!m_ready) begin
            run_next = '0;
        end else if (run_reg == RUN_FULL) begin
            run_next = run_reg;
        end else begin
            run_next = run_reg + RW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= '0;
        end else begin
            run_reg <= run_next;
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_curve_x) && $stable(m_curve_y)
            && $stable(m_curve_z) && $stable(m_zero_count_error))
        else $error("stalled result changed");

    // a draining receiver never backs up the input side
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("s_ready low while m_ready high");

    // pipeline is empty right after reset
    a_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result shown right after reset");

    // zero-count request reaches the output on time when never stalled
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(s_valid && s_ready && (s_segment_count == '0) && aresetn, DEPTH + 1)
            && (run_reg == RUN_FULL)
        |-> m_valid && m_zero_count_error)
        else $error("zero-count flag missing at expected latency");

endmodule

bind quadratic_bezier_point_unit qbp_checker #(
    .T_FRAC_BITS (T_FRAC_BITS)
) u_qbp_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .s_segment_count    (s_segment_count),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_curve_x          (m_curve_x),
    .m_curve_y          (m_curve_y),
    .m_curve_z          (m_curve_z),
    .m_zero_count_error (m_zero_count_error)
);

[verif/quadratic_bezier_point_unit_tb.sv]
// testbench for the quadratic bezier point unit: queued requests, self-checking monitor
`timescale 1ns / 1ps

module quadratic_bezier_point_unit_tb;

    localparam int unsigned COORD_W     = qbp_pkg::COORD_W;
    localparam int unsigned CNT_W       = qbp_pkg::CNT_W;
    localparam int unsigned AXES        = qbp_pkg::AXES;
    localparam int unsigned T_FRAC_BITS = qbp_pkg::T_FRAC_BITS;
    localparam logic [COORD_W-1:0] COORD_MAX = qbp_pkg::COORD_MAX;
    localparam logic [COORD_W-1:0] COORD_MIN = qbp_pkg::COORD_MIN;

    localparam int unsigned RST_CYCLES  = 6;
    localparam int unsigned RAND_REQS   = 1150;
    localparam int unsigned IDLE_LIMIT  = 4000;
    localparam int unsigned TAIL_CYCLES = 30;

    typedef struct packed {
        qbp_pkg::qbp_pts_t pts;
        logic [CNT_W-1:0]  point_index;
        logic [CNT_W-1:0]  segment_count;
        logic              drain_first;
    } bez_req_t;

    typedef struct packed {
        qbp_pkg::qbp_vec_t point;
        logic              zero_cnt;
    } curve_pt_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_start_x;
    logic signed [COORD_W-1:0] s_start_y;
    logic signed [COORD_W-1:0] s_start_z;
    logic signed [COORD_W-1:0] s_control_x;
    logic signed [COORD_W-1:0] s_control_y;
    logic signed [COORD_W-1:0] s_control_z;
    logic signed [COORD_W-1:0] s_end_x;
    logic signed [COORD_W-1:0] s_end_y;
    logic signed [COORD_W-1:0] s_end_z;
    logic        [CNT_W-1:0]   s_point_index;
    logic        [CNT_W-1:0]   s_segment_count;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [COORD_W-1:0] m_curve_x;
    logic signed [COORD_W-1:0] m_curve_y;
    logic signed [COORD_W-1:0] m_curve_z;
    logic                      m_zero_count_error;

    bez_req_t    pending_q[$];
    curve_pt_t   curve_exp_q[$];
    int unsigned mismatch_cnt = 0;
    int unsigned result_seq   = 0;
    int unsigned idle_cycles  = 0;
    bit          req_fire     = 1'b0;
    int unsigned burst_left   = 0;
    int unsigned gap_left     = 0;
    int unsigned rx_left      = 0;
    int unsigned rx_mode      = 0;

    quadratic_bezier_point_unit u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_start_x         (s_start_x),
        .s_start_y         (s_start_y),
        .s_start_z         (s_start_z),
        .s_control_x       (s_control_x),
        .s_control_y       (s_control_y),
        .s_control_z       (s_control_z),
        .s_end_x           (s_end_x),
        .s_end_y           (s_end_y),
        .s_end_z           (s_end_z),
        .s_point_index     (s_point_index),
        .s_segment_count   (s_segment_count),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_curve_x         (m_curve_x),
        .m_curve_y         (m_curve_y),
        .m_curve_z         (m_curve_z),
        .m_zero_count_error(m_zero_count_error)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic curve_pt_t curve_point(bez_req_t r);
        longint unsigned idx;
        longint unsigned cnt;
        longint unsigned t;
        longint unsigned u;
        longint          w0;
        longint          w1;
        longint          w2;
        longint          sum;
        longint          sat_hi;
        longint          sat_lo;
        longint          cs;
        longint          cc;
        longint          ce;
        curve_pt_t       p;
        idx = r.point_index;
        cnt = r.segment_count;
        sat_hi = $signed(COORD_MAX);
        sat_lo = $signed(COORD_MIN);
        p.zero_cnt = (cnt == 0);
        if (cnt == 0) begin
            t = 0;
        end else begin
            if (idx > cnt) begin
                idx = cnt;
            end
            t = (idx << T_FRAC_BITS) / cnt;
        end
        u  = (64'd1 << T_FRAC_BITS) - t;
        w0 = longint'((u * u) >> T_FRAC_BITS);
        w1 = longint'((2 * u * t) >> T_FRAC_BITS);
        w2 = longint'((t * t) >> T_FRAC_BITS);
        for (int a = 0; a < AXES; a++) begin
            cs = $signed(r.pts.s[a]);
            cc = $signed(r.pts.c[a]);
            ce = $signed(r.pts.e[a]);
            // arithmetic shift of a signed product floors toward minus infinity
            sum = ((cs * w0) >>> T_FRAC_BITS) + ((cc * w1) >>> T_FRAC_BITS)
                + ((ce * w2) >>> T_FRAC_BITS);
            if (sum > sat_hi) begin
                sum = sat_hi;
            end else if (sum < sat_lo) begin
                sum = sat_lo;
            end
            p.point[a] = sum[COORD_W-1:0];
        end
        return p;
    endfunction

    function automatic qbp_pkg::qbp_vec_t vec3(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                               logic [COORD_W-1:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return COORD_W'($urandom_range(0, 4)) - COORD_W'(2);
            3: return COORD_W'($urandom_range(0, 131071)) - COORD_W'(65536);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_req(qbp_pkg::qbp_vec_t s, qbp_pkg::qbp_vec_t c, qbp_pkg::qbp_vec_t e,
                             logic [CNT_W-1:0] idx, logic [CNT_W-1:0] cnt, logic drain);
        bez_req_t r;
        r.pts.s         = s;
        r.pts.c         = c;
        r.pts.e         = e;
        r.point_index   = idx;
        r.segment_count = cnt;
        r.drain_first   = drain;
        pending_q.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [COORD_W-1:0] got,
                                   logic [COORD_W-1:0] want);
        $display("MISMATCH result %0d %s: got %h expected %h", result_seq, what, got, want);
        mismatch_cnt++;
    endtask

    // request and result side: accept, predict, and check results
    always @(posedge aclk) begin
        bez_req_t taken;
        curve_pt_t want;
        req_fire = aresetn && s_valid && s_ready;
        if (req_fire) begin
            taken.pts.s         = vec3(s_start_x, s_start_y, s_start_z);
            taken.pts.c         = vec3(s_control_x, s_control_y, s_control_z);
            taken.pts.e         = vec3(s_end_x, s_end_y, s_end_z);
            taken.point_index   = s_point_index;
            taken.segment_count = s_segment_count;
            taken.drain_first   = 1'b0;
            curve_exp_q.push_back(curve_point(taken));
            void'(pending_q.pop_front());
        end
        if (aresetn && m_valid && m_ready) begin
            if (curve_exp_q.size() == 0) begin
                report_mismatch("unexpected result", m_curve_x, '0);
            end else begin
                want = curve_exp_q.pop_front();
                if (m_curve_x !== want.point[0]) begin
                    report_mismatch("curve_x", m_curve_x, want.point[0]);
                end
                if (m_curve_y !== want.point[1]) begin
                    report_mismatch("curve_y", m_curve_y, want.point[1]);
                end
                if (m_curve_z !== want.point[2]) begin
                    report_mismatch("curve_z", m_curve_z, want.point[2]);
                end
                if (m_zero_count_error !== want.zero_cnt) begin
                    report_mismatch("zero_count_error", COORD_W'(m_zero_count_error),
                                    COORD_W'(want.zero_cnt));
                end
            end
            result_seq++;
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // sender: bursts with gaps, holds a request until it is taken
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || req_fire)) begin
            if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_q.size() == 0 ||
                         (pending_q[0].drain_first && curve_exp_q.size() != 0)) begin
                s_valid <= 1'b0;
            end else begin
                s_start_x       <= pending_q[0].pts.s[0];
                s_start_y       <= pending_q[0].pts.s[1];
                s_start_z       <= pending_q[0].pts.s[2];
                s_control_x     <= pending_q[0].pts.c[0];
                s_control_y     <= pending_q[0].pts.c[1];
                s_control_z     <= pending_q[0].pts.c[2];
                s_end_x         <= pending_q[0].pts.e[0];
                s_end_y         <= pending_q[0].pts.e[1];
                s_end_z         <= pending_q[0].pts.e[2];
                s_point_index   <= pending_q[0].point_index;
                s_segment_count <= pending_q[0].segment_count;
                s_valid         <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // receiver: phases of full rate, random stalls, sparse accepts and solid stalls
    always @(negedge aclk) begin
        if (aresetn) begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = (rx_mode == 3) ? $urandom_range(1, 40) : $urandom_range(8, 64);
            end
            rx_left--;
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= 1'b0;
            endcase
        end
    end

    initial begin
        logic [CNT_W-1:0] idx;
        logic [CNT_W-1:0] cnt;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        m_ready         = 1'b0;
        s_start_x       = '0;
        s_start_y       = '0;
        s_start_z       = '0;
        s_control_x     = '0;
        s_control_y     = '0;
        s_control_z     = '0;
        s_end_x         = '0;
        s_end_y         = '0;
        s_end_z         = '0;
        s_point_index   = '0;
        s_segment_count = '0;

        // zero count forces the start point and raises the error flag
        queue_req(vec3(0, 0, 0), vec3(0, 0, 0), vec3(0, 0, 0), 16'd0, 16'd0, 1'b0);
        queue_req(vec3(COORD_MAX, COORD_MIN, 32'hFFFF_FFFF), vec3(COORD_MIN, COORD_MAX, 0),
                  vec3(COORD_MAX, COORD_MAX, COORD_MIN), 16'hFFFF, 16'd0, 1'b0);
        // t at both ends
        queue_req(vec3(32'h0001_8000, COORD_MIN, 32'hFFFF_FFFF), vec3(COORD_MAX, 0, 1),
                  vec3(COORD_MIN, COORD_MAX, 32'h1234_5678), 16'd0, 16'd1, 1'b0);
        queue_req(vec3(COORD_MAX, 0, 1), vec3(COORD_MIN, COORD_MIN, COORD_MIN),
                  vec3(COORD_MIN, COORD_MAX, 32'hFFFF_FFFF), 16'd1, 16'd1, 1'b0);
        // index past the count clamps to the end point
        queue_req(vec3(1, 2, 3), vec3(4, 5, 6), vec3(COORD_MAX, COORD_MIN, 32'hDEAD_BEEF),
                  16'hFFFF, 16'd3, 1'b0);
        queue_req(vec3(7, 8, 9), vec3(10, 11, 12), vec3(32'h8000_0001, 32'h7FFF_FFFE, 0),
                  16'hFFFF, 16'd1, 1'b0);
        // midpoint with extreme coordinates
        queue_req(vec3(COORD_MIN, COORD_MIN, COORD_MIN), vec3(COORD_MIN, COORD_MIN, COORD_MIN),
                  vec3(COORD_MIN, COORD_MIN, COORD_MIN), 16'd1, 16'd2, 1'b0);
        queue_req(vec3(COORD_MAX, COORD_MAX, COORD_MAX), vec3(COORD_MAX, COORD_MAX, COORD_MAX),
                  vec3(COORD_MAX, COORD_MAX, COORD_MAX), 16'd1, 16'd2, 1'b0);
        queue_req(vec3(COORD_MIN, COORD_MIN, COORD_MIN), vec3(COORD_MAX, COORD_MAX, COORD_MAX),
                  vec3(COORD_MIN, COORD_MIN, COORD_MIN), 16'd1, 16'd2, 1'b0);
        queue_req(vec3(COORD_MAX, COORD_MAX, COORD_MAX), vec3(COORD_MIN, COORD_MIN, COORD_MIN),
                  vec3(COORD_MAX, COORD_MAX, COORD_MAX), 16'd1, 16'd2, 1'b0);
        // truncated weights, negative terms floor down
        queue_req(vec3(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                  vec3(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                  vec3(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 16'd1, 16'd3, 1'b0);
        queue_req(vec3(COORD_MAX, COORD_MIN, 32'h0000_FFFF), vec3(COORD_MIN, COORD_MAX, 1),
                  vec3(COORD_MAX, COORD_MIN, 32'hFFFF_0001), 16'd2, 16'd3, 1'b0);
        queue_req(vec3(COORD_MAX, 32'h0001_0000, COORD_MIN), vec3(0, COORD_MAX, 32'hFFFF_0000),
                  vec3(COORD_MIN, 32'h0002_0000, COORD_MAX), 16'hFFFE, 16'hFFFF, 1'b0);
        queue_req(vec3(COORD_MIN, 32'h0001_0000, COORD_MAX), vec3(COORD_MAX, COORD_MIN, 0),
                  vec3(COORD_MAX, 32'hFFFE_0000, COORD_MIN), 16'd1, 16'hFFFF, 1'b0);
        queue_req(vec3(1, 2, 3), vec3(COORD_MAX, COORD_MIN, COORD_MAX),
                  vec3(COORD_MIN, COORD_MAX, COORD_MIN), 16'hFFFF, 16'hFFFF, 1'b0);
        queue_req(vec3(COORD_MIN, COORD_MAX, 32'hFFFF_FFFF), vec3(COORD_MAX, COORD_MIN, 1),
                  vec3(32'h0003_0000, 32'hFFFD_0000, 0), 16'h8000, 16'hFFFF, 1'b0);
        queue_req(vec3(COORD_MIN, 5, 32'hFFFF_FFFB), vec3(0, 0, 0),
                  vec3(COORD_MAX, 7, 32'hFFFF_FFF9), 16'd0, 16'hFFFF, 1'b0);
        queue_req(vec3(32'h0000_0003, 32'hFFFF_FFFD, 32'h0001_0001),
                  vec3(32'h0000_0005, 32'hFFFF_FFFB, 32'hFFFE_FFFF),
                  vec3(32'h0000_0007, 32'hFFFF_FFF9, 32'h0000_8001), 16'd7, 16'd10, 1'b0);
        queue_req(vec3(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA),
                  vec3(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555),
                  vec3(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA), 16'h5555, 16'hAAAA, 1'b0);
        queue_req(vec3(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555),
                  vec3(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA),
                  vec3(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555), 16'hAAAA, 16'h5555, 1'b0);

        for (int i = 0; i < RAND_REQS; i++) begin
            case ($urandom_range(0, 9))
                0: begin
                    cnt = 16'd0;
                    idx = CNT_W'($urandom);
                end
                1, 2: begin
                    cnt = CNT_W'($urandom_range(1, 16));
                    idx = CNT_W'($urandom_range(0, 20));
                end
                3: begin
                    cnt = CNT_W'($urandom);
                    idx = CNT_W'($urandom);
                end
                4: begin
                    cnt = CNT_W'($urandom_range(1, 65535));
                    idx = ($urandom_range(0, 1) == 0) ? cnt : 16'd0;
                end
                default: begin
                    cnt = CNT_W'($urandom_range(1, 65535));
                    idx = CNT_W'($urandom_range(0, cnt));
                end
            endcase
            // the first random request and one in the middle wait for the pipe to drain
            queue_req(vec3(rand_coord(), rand_coord(), rand_coord()),
                      vec3(rand_coord(), rand_coord(), rand_coord()),
                      vec3(rand_coord(), rand_coord(), rand_coord()),
                      idx, cnt, (i == 0) || (i == RAND_REQS / 2));
        end

        repeat (RST_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || curve_exp_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
